// File: sv/assert_macros.svh
// Assertion macros shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk_i, disabled while rst_ni is low.
`define APIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, for a property that must also hold during reset.
`define APIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/apit_pkg.sv
// Types, constants and a helper function for the pending/in-service tracker.
`default_nettype none

package apit_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned IdxW     = $clog2(NumWords);
  localparam int unsigned BitW     = $clog2(WordW);
  localparam int unsigned VecW     = IdxW + BitW;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_WIN_EXIT = 2'd1,
    OP_EOI      = 2'd2,
    OP_SPURIOUS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CTL_NONE    = 2'd0,
    CTL_ENABLE  = 2'd1,
    CTL_DISABLE = 2'd2
  } ctl_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the incoming item
    logic dec_idx;  // step the word index down
    logic exec;     // update one word and load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;        // op of the item held
    logic sel_nz;    // selected set has a nonzero word at the index
    logic idx_zero;  // index is at the lowest word
    logic out_busy;  // output register holds an untaken item
  } sts_t;

  // Highest set bit; 0 for an all-zero word.
  function automatic logic [BitW-1:0] highest_bit(input logic [WordW-1:0] w);
    logic [BitW-1:0] n;
    n = '0;
    for (int unsigned i = 0; i < WordW; i++) begin
      if (w[i]) begin
        n = BitW'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/apic_pending_inservice_tracker.sv
// Top level of the pending / in-service interrupt vector tracker.
//
// Input channel (in_valid_i / in_ready_o) carries one item: op_i, vector_i,
// window_open_i. Output channel (out_valid_o / out_ready_i) returns exactly
// one item per input item, in order: inject flag and vector, window exiting
// control, and the empty flags of both sets after the update.
// Ops: request (inject if the window is open, else mark pending and enable
// exiting), window exit (pop and inject the highest pending vector, vector 0
// when none), end of interrupt (retire the highest in-service vector),
// spurious (inject only when the window is open, no state change).
// One item is worked at a time. Request and spurious items pass from the
// accept edge through an index check and the execute step to output valid.
// Window exit and end of interrupt scan the per-word nonzero flags of the
// chosen set from the top word down, one word per cycle, until a nonzero
// word or the lowest word is reached, then execute. A new item is accepted
// the cycle after the execute step.
// A result waiting in the output register does not block acceptance; the
// execute step stalls only while that register is still full and untaken.
// Asynchronous reset (rst_ni low) clears both 256-bit sets and control state.
`default_nettype none

module apic_pending_inservice_tracker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] vector_i,
  input  wire logic       window_open_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            inject_valid_o,
  output logic [7:0]      inject_vector_o,
  output logic [1:0]      window_ctl_o,
  output logic            pending_empty_o,
  output logic            inservice_empty_o
);

  apit_pkg::cmd_t cmd;
  apit_pkg::sts_t sts;

  apit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  apit_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op_i),
    .vector_i          (vector_i),
    .window_open_i     (window_open_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .inject_valid_o    (inject_valid_o),
    .inject_vector_o   (inject_vector_o),
    .window_ctl_o      (window_ctl_o),
    .pending_empty_o   (pending_empty_o),
    .inservice_empty_o (inservice_empty_o)
  );

endmodule

`default_nettype wire

// File: sv/apit_ctrl.sv
// Sequencer for the tracker: accept, word scan, execute.
`default_nettype none

`include "assert_macros.svh"

module apit_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output apit_pkg::cmd_t     cmd_o,
  input  wire apit_pkg::sts_t sts_i
);

  apit_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apit_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      apit_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = apit_pkg::ST_SCAN;
        end
      end
      apit_pkg::ST_SCAN: begin
        // request and spurious items already point at their word
        if (sts_i.op == apit_pkg::OP_REQUEST || sts_i.op == apit_pkg::OP_SPURIOUS ||
            sts_i.sel_nz || sts_i.idx_zero) begin
          state_d = apit_pkg::ST_EXEC;
        end else begin
          cmd_o.dec_idx = 1'b1;
        end
      end
      apit_pkg::ST_EXEC: begin
        if (!sts_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = apit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = apit_pkg::ST_IDLE;
      end
    endcase
  end

  `APIT_ASSERT(a_scan_ends_at_zero,
    (state_q == apit_pkg::ST_SCAN && sts_i.idx_zero) |=> (state_q == apit_pkg::ST_EXEC),
    "scan ran past the lowest word")
  `APIT_ASSERT(a_exec_only_free,
    cmd_o.exec |-> (state_q == apit_pkg::ST_EXEC && !sts_i.out_busy),
    "execute issued while output register is full")

endmodule

`default_nettype wire

// File: sv/apit_dpath.sv
// Vector set storage, word update logic and output register.
`default_nettype none

`include "assert_macros.svh"

module apit_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [1:0]           op_i,
  input  wire logic [7:0]           vector_i,
  input  wire logic                 window_open_i,
  input  wire apit_pkg::cmd_t       cmd_i,
  output apit_pkg::sts_t            sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      inject_valid_o,
  output logic [7:0]                inject_vector_o,
  output logic [1:0]                window_ctl_o,
  output logic                      pending_empty_o,
  output logic                      inservice_empty_o
);

  localparam int unsigned NumWords = apit_pkg::NumWords;
  localparam int unsigned WordW    = apit_pkg::WordW;
  localparam int unsigned IdxW     = apit_pkg::IdxW;
  localparam int unsigned BitW     = apit_pkg::BitW;

  // vector sets, one word per row, plus a nonzero flag per word
  logic [WordW-1:0]    pend_q [NumWords];
  logic [WordW-1:0]    ins_q  [NumWords];
  logic [NumWords-1:0] pend_nz_q, pend_nz_d;
  logic [NumWords-1:0] ins_nz_q,  ins_nz_d;

  // held item
  apit_pkg::op_e op_q;
  logic [7:0]    vector_q;
  logic          open_q;
  logic [IdxW-1:0] idx_q, idx_d;

  // output register
  logic       out_valid_q;
  logic       inj_valid_q, inj_valid_d;
  logic [7:0] inj_vec_q, inj_vec_d;
  logic [1:0] ctl_q, ctl_d;
  logic       pend_empty_q, ins_empty_q;

  logic [WordW-1:0] pw, iw, sw, pw_n, iw_n, mask;
  logic [BitW-1:0]  top_b, bsel;

  always_comb begin
    pw    = pend_q[idx_q];
    iw    = ins_q[idx_q];
    sw    = (op_q == apit_pkg::OP_WIN_EXIT) ? pw : iw;
    top_b = apit_pkg::highest_bit(sw);
    bsel  = (op_q == apit_pkg::OP_REQUEST) ? vector_q[BitW-1:0] : top_b;
    mask  = WordW'(1) << bsel;

    pw_n        = pw;
    iw_n        = iw;
    inj_valid_d = 1'b0;
    inj_vec_d   = '0;
    ctl_d       = apit_pkg::CTL_NONE;
    pend_nz_d   = pend_nz_q;
    ins_nz_d    = ins_nz_q;

    case (op_q)
      apit_pkg::OP_REQUEST: begin
        if (open_q) begin
          pw_n        = pw & ~mask;
          iw_n        = iw | mask;
          inj_valid_d = 1'b1;
          inj_vec_d   = vector_q;
        end else begin
          pw_n  = pw | mask;
          ctl_d = apit_pkg::CTL_ENABLE;
        end
      end
      apit_pkg::OP_WIN_EXIT: begin
        // an empty set leaves the index at word 0 with bit 0: vector 0
        pw_n        = pw & ~mask;
        iw_n        = iw | mask;
        inj_valid_d = 1'b1;
        inj_vec_d   = {idx_q, top_b};
      end
      apit_pkg::OP_EOI: begin
        iw_n = iw & ~mask;
      end
      apit_pkg::OP_SPURIOUS: begin
        inj_valid_d = open_q;
        inj_vec_d   = open_q ? vector_q : 8'd0;
      end
      default: begin
      end
    endcase

    pend_nz_d[idx_q] = |pw_n;
    ins_nz_d[idx_q]  = |iw_n;
    if (op_q == apit_pkg::OP_WIN_EXIT) begin
      ctl_d = (pend_nz_d == '0) ? apit_pkg::CTL_DISABLE : apit_pkg::CTL_ENABLE;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      if (apit_pkg::op_e'(op_i) == apit_pkg::OP_REQUEST ||
          apit_pkg::op_e'(op_i) == apit_pkg::OP_SPURIOUS) begin
        idx_d = vector_i[7 -: IdxW];
      end else begin
        idx_d = IdxW'(NumWords - 1);
      end
    end else if (cmd_i.dec_idx) begin
      idx_d = idx_q - IdxW'(1);
    end
  end

  // set words: reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumWords; i++) begin
        pend_q[i] <= '0;
        ins_q[i]  <= '0;
      end
      pend_nz_q <= '0;
      ins_nz_q  <= '0;
    end else if (cmd_i.exec) begin
      pend_q[idx_q] <= pw_n;
      ins_q[idx_q]  <= iw_n;
      pend_nz_q     <= pend_nz_d;
      ins_nz_q      <= ins_nz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      op_q        <= apit_pkg::OP_REQUEST;
      idx_q       <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.load) begin
        op_q <= apit_pkg::op_e'(op_i);
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vector_q <= vector_i;
      open_q   <= window_open_i;
    end
    if (cmd_i.exec) begin
      inj_valid_q  <= inj_valid_d;
      inj_vec_q    <= inj_vec_d;
      ctl_q        <= ctl_d;
      pend_empty_q <= (pend_nz_d == '0);
      ins_empty_q  <= (ins_nz_d == '0);
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.sel_nz   = (op_q == apit_pkg::OP_WIN_EXIT) ? pend_nz_q[idx_q] : ins_nz_q[idx_q];
    sts_o.idx_zero = (idx_q == '0);
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign inject_valid_o    = inj_valid_q;
  assign inject_vector_o   = inj_vec_q;
  assign window_ctl_o      = ctl_q;
  assign pending_empty_o   = pend_empty_q;
  assign inservice_empty_o = ins_empty_q;

  `APIT_ASSERT(a_exec_gives_item, cmd_i.exec |=> out_valid_q,
    "executed item did not reach the output register")
  `APIT_ASSERT(a_exit_injects,
    (cmd_i.exec && op_q == apit_pkg::OP_WIN_EXIT) |=>
      (inj_valid_q && (ctl_q == apit_pkg::CTL_ENABLE || ctl_q == apit_pkg::CTL_DISABLE)),
    "window exit without injection or exiting control")
  `APIT_ASSERT(a_disable_means_empty,
    (cmd_i.exec && op_q == apit_pkg::OP_WIN_EXIT && pend_nz_d == '0) |=>
      (ctl_q == apit_pkg::CTL_DISABLE && pend_empty_q),
    "exiting not disabled with nothing pending")

endmodule

`default_nettype wire

// File: tb/sv/apit_delivery_checker.sv
// Watches both channels of the tracker, predicts each result and compares it.
`default_nettype none

module apit_delivery_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] vector_i,
  input  wire logic       window_open_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic       inject_valid_i,
  input  wire logic [7:0] inject_vector_i,
  input  wire logic [1:0] window_ctl_i,
  input  wire logic       pending_empty_i,
  input  wire logic       inservice_empty_i,
  output int              fail_count_o,
  output int              outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic           inject;
    logic [7:0]     vector;
    apit_pkg::ctl_e ctl;
    logic           pend_empty;
    logic           isr_empty;
  } delivery_t;

  // Own copy of both vector sets; bit v stands for vector v.
  logic [255:0] pending_set;
  logic [255:0] inservice_set;
  delivery_t    expected_deliveries[$];
  int           results_seen;

  // Highest member of a set, vector 0 for an empty set.
  function automatic logic [7:0] highest_member(input logic [255:0] s);
    logic [7:0] v;
    v = '0;
    for (int i = 0; i < 256; i++) begin
      if (s[i]) begin
        v = 8'(i);
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_count_o < 100) begin
      $display("%0t: result %0d, %s is %0h, expected %0h", $realtime, results_seen,
               field, got, want);
    end
    fail_count_o++;
  endtask

  // Applies one accepted item to the sets and queues the result it must give.
  task automatic predict_delivery(input apit_pkg::op_e op, input logic [7:0] vec,
                                  input logic open);
    delivery_t  d;
    logic [7:0] top;
    d.inject = 1'b0;
    d.vector = '0;
    d.ctl    = apit_pkg::CTL_NONE;
    case (op)
      apit_pkg::OP_REQUEST: begin
        if (open) begin
          pending_set[vec]   = 1'b0;
          inservice_set[vec] = 1'b1;
          d.inject           = 1'b1;
          d.vector           = vec;
        end else begin
          pending_set[vec] = 1'b1;
          d.ctl            = apit_pkg::CTL_ENABLE;
        end
      end
      apit_pkg::OP_WIN_EXIT: begin
        // empty pending set still injects vector 0
        top                = highest_member(pending_set);
        pending_set[top]   = 1'b0;
        inservice_set[top] = 1'b1;
        d.inject           = 1'b1;
        d.vector           = top;
        d.ctl              = (pending_set == '0) ? apit_pkg::CTL_DISABLE
                                                 : apit_pkg::CTL_ENABLE;
      end
      apit_pkg::OP_EOI: begin
        if (inservice_set != '0) begin
          inservice_set[highest_member(inservice_set)] = 1'b0;
        end
      end
      default: begin
        if (open) begin
          d.inject = 1'b1;
          d.vector = vec;
        end
      end
    endcase
    d.pend_empty = (pending_set == '0);
    d.isr_empty  = (inservice_set == '0);
    expected_deliveries.push_back(d);
  endtask

  task automatic check_delivery();
    delivery_t want;
    if (expected_deliveries.size() == 0) begin
      report_mismatch("unexpected result", inject_vector_i, 8'h0);
    end else begin
      want = expected_deliveries.pop_front();
      if (inject_valid_i !== want.inject)
        report_mismatch("inject_valid", 8'(inject_valid_i), 8'(want.inject));
      if (inject_vector_i !== want.vector)
        report_mismatch("inject_vector", inject_vector_i, want.vector);
      if (window_ctl_i !== want.ctl)
        report_mismatch("window_ctl", 8'(window_ctl_i), 8'(want.ctl));
      if (pending_empty_i !== want.pend_empty)
        report_mismatch("pending_empty", 8'(pending_empty_i), 8'(want.pend_empty));
      if (inservice_empty_i !== want.isr_empty)
        report_mismatch("inservice_empty", 8'(inservice_empty_i), 8'(want.isr_empty));
    end
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_set   = '0;
      inservice_set = '0;
      expected_deliveries.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_delivery();
      end
      if (in_valid_i && in_ready_i) begin
        predict_delivery(apit_pkg::op_e'(op_i), vector_i, window_open_i);
      end
    end
    outstanding_o = expected_deliveries.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Top of the tracker testbench: clock, reset, stimulus, receiver and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] op_i;
  logic [7:0] vector_i;
  logic       window_open_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       inject_valid_o;
  logic [7:0] inject_vector_o;
  logic [1:0] window_ctl_o;
  logic       pending_empty_o;
  logic       inservice_empty_o;

  int fail_count;
  int outstanding;

  // Set by the stimulus right after an accept edge, read by the receiver at
  // the next falling edge, so there is no same-step race on them.
  bit hold_out_req = 1'b0;  // one long receiver hold-off
  bit quiet_tail   = 1'b0;  // no idling on either side from here on

  always #4 clk_i = ~clk_i;

  apic_pending_inservice_tracker uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .vector_i         (vector_i),
    .window_open_i    (window_open_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .inject_valid_o   (inject_valid_o),
    .inject_vector_o  (inject_vector_o),
    .window_ctl_o     (window_ctl_o),
    .pending_empty_o  (pending_empty_o),
    .inservice_empty_o(inservice_empty_o)
  );

  apit_delivery_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .op_i             (op_i),
    .vector_i         (vector_i),
    .window_open_i    (window_open_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .inject_valid_i   (inject_valid_o),
    .inject_vector_i  (inject_vector_o),
    .window_ctl_i     (window_ctl_o),
    .pending_empty_i  (pending_empty_o),
    .inservice_empty_i(inservice_empty_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  // Offers one item, after an optional idle burst, and returns at the edge
  // that accepts it. Valid stays high across back-to-back items; the payload
  // only changes at a falling edge after the previous accept.
  task automatic send_item(input apit_pkg::op_e op, input logic [7:0] vec,
                           input logic open);
    int gap;
    gap = (!quiet_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    vector_i      <= vec;
    window_open_i <= open;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  // Stops offering and waits until every predicted result has come back.
  // The count is updated at rising edges, so it is read at falling ones.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, one long hold-off on request (long enough
  // that the tracker fills and drops in_ready), and no stalls at all once the
  // tail of the run starts.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (80) @(negedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run (about 1000 items, even with
  // both sides stalling at their worst).
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int            roll;
    apit_pkg::op_e op;
    logic [7:0]    vec;

    in_valid_i    = 1'b0;
    op_i          = apit_pkg::OP_REQUEST;
    vector_i      = '0;
    window_open_i = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, from the reset state (both sets empty).
    send_item(apit_pkg::OP_EOI, 8'h00, 1'b0);       // EOI with nothing in service
    send_item(apit_pkg::OP_WIN_EXIT, 8'hA5, 1'b1);  // nothing pending: injects 0
    send_item(apit_pkg::OP_EOI, 8'h5A, 1'b1);       // retires vector 0
    send_item(apit_pkg::OP_REQUEST, 8'd0, 1'b0);    // word and bit extremes, closed
    send_item(apit_pkg::OP_REQUEST, 8'd255, 1'b0);
    send_item(apit_pkg::OP_REQUEST, 8'd31, 1'b0);
    send_item(apit_pkg::OP_REQUEST, 8'd32, 1'b0);
    send_item(apit_pkg::OP_WIN_EXIT, 8'h00, 1'b0);  // pops 255, more left: enable
    send_item(apit_pkg::OP_WIN_EXIT, 8'hFF, 1'b0);  // pops 32
    send_item(apit_pkg::OP_WIN_EXIT, 8'h00, 1'b1);  // pops 31
    send_item(apit_pkg::OP_WIN_EXIT, 8'h00, 1'b0);  // pops 0, last one: disable
    send_item(apit_pkg::OP_EOI, 8'h00, 1'b0);       // highest in service first
    send_item(apit_pkg::OP_EOI, 8'h00, 1'b0);
    send_item(apit_pkg::OP_EOI, 8'h00, 1'b0);
    send_item(apit_pkg::OP_EOI, 8'h00, 1'b0);
    send_item(apit_pkg::OP_REQUEST, 8'd100, 1'b0);  // pending, then injected directly,
    send_item(apit_pkg::OP_REQUEST, 8'd100, 1'b1);  // which clears the pending bit
    send_item(apit_pkg::OP_WIN_EXIT, 8'h00, 1'b0);  // empty again: vector 0
    send_item(apit_pkg::OP_REQUEST, 8'd255, 1'b1);  // direct injects at both extremes
    send_item(apit_pkg::OP_REQUEST, 8'd0, 1'b1);
    send_item(apit_pkg::OP_SPURIOUS, 8'd200, 1'b1); // spurious injects, no state change
    send_item(apit_pkg::OP_SPURIOUS, 8'd201, 1'b0); // spurious with window closed
    send_item(apit_pkg::OP_SPURIOUS, 8'd255, 1'b1);
    send_item(apit_pkg::OP_EOI, 8'h00, 1'b0);
    send_item(apit_pkg::OP_EOI, 8'h00, 1'b0);

    // Random part. Closed-window requests build up the pending set, exits
    // and EOIs drain the two sets, so both see long and short scans. Half the
    // vectors sit in the top or bottom word to stress the scan extremes.
    for (int n = 0; n < 950; n++) begin
      if (n == 300) hold_out_req = 1'b1;
      if (n == 600) wait_results_drained();
      if (n == 830) quiet_tail = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 40) op = apit_pkg::OP_REQUEST;
      else if (roll < 65) op = apit_pkg::OP_WIN_EXIT;
      else if (roll < 90) op = apit_pkg::OP_EOI;
      else op = apit_pkg::OP_SPURIOUS;
      case ($urandom_range(0, 3))
        0:       vec = 8'($urandom_range(0, 31));
        1:       vec = 8'($urandom_range(224, 255));
        default: vec = 8'($urandom_range(0, 255));
      endcase
      send_item(op, vec, 1'($urandom_range(0, 1)));
    end

    wait_results_drained();
    // let any stray extra result show up before the verdict
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
